### design/fas_pkg.sv
// Shared types, codes and constants for the finite automaton stepper.
package fas_pkg;

	localparam int unsigned FAS_MAX_STATES  = 64;
	localparam int unsigned FAS_MAX_SYMBOLS = 16;

	localparam int unsigned SET_W    = 64;
	localparam int unsigned STATE_W  = 6;
	localparam int unsigned SYMBOL_W = 4;
	localparam int unsigned SCNT_W   = 7;
	localparam int unsigned YCNT_W   = 5;

	// reset values of the configuration registers
	localparam logic              DFA_MODE_RST       = 1'b0;
	localparam logic [SCNT_W-1:0] STATE_COUNT_RST    = 7'd64;
	localparam logic [YCNT_W-1:0] SYMBOL_COUNT_RST   = 5'd16;
	localparam logic [STATE_W-1:0] START_STATE_RST   = 6'd0;
	localparam logic [SET_W-1:0]  ACCEPTING_MASK_RST = 64'd0;

	typedef enum logic [2:0] {
		CFG_DFA_MODE       = 3'd0,
		CFG_STATE_COUNT    = 3'd1,
		CFG_SYMBOL_COUNT   = 3'd2,
		CFG_START_STATE    = 3'd3,
		CFG_ACCEPTING_MASK = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_BEGIN  = 2'd1,
		OP_SYMBOL = 2'd2,
		OP_END    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_DEAD    = 2'd1,
		STS_INVALID = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} fas_state_t;

	typedef struct packed {
		logic                dfa_mode;
		logic [SCNT_W-1:0]   state_count;
		logic [YCNT_W-1:0]   symbol_count;
		logic [STATE_W-1:0]  start_state;
		logic [SET_W-1:0]    accepting_mask;
	} cfg_t;

	// result word: active set, accepted flag, status
	localparam int unsigned RESULT_W = SET_W + 1 + 2;

endpackage

### design/fas_table.sv
// Transition table: one write port, one read port with registered read data.
module fas_table import fas_pkg::*; #(
	parameter int unsigned DEPTH = FAS_MAX_STATES * FAS_MAX_SYMBOLS,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [SET_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [SET_W-1:0] rdata
);

	logic [SET_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/fas_core.sv
// Sequencer: table clear sweep, loads, row scan per symbol and result register.
module fas_core import fas_pkg::*; #(
	parameter int unsigned MAX_STATES  = FAS_MAX_STATES,
	parameter int unsigned MAX_SYMBOLS = FAS_MAX_SYMBOLS,
	localparam int unsigned DEPTH      = MAX_STATES * MAX_SYMBOLS,
	localparam int unsigned AW         = $clog2(DEPTH),
	localparam int unsigned SW         = $clog2(MAX_STATES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  op_t                 in_op,
	input  logic [STATE_W-1:0]  in_state,
	input  logic [SYMBOL_W-1:0] in_symbol,
	input  logic [SET_W-1:0]    in_targets,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [RESULT_W-1:0] out_data,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output logic [SET_W-1:0]    mem_wdata,
	output logic                mem_re,
	output logic [AW-1:0]       mem_raddr,
	input  logic [SET_W-1:0]    mem_rdata
);

	fas_state_t state_q, state_d;

	logic [AW-1:0]       clr_q;
	logic [SW-1:0]       cnt_q;
	logic [SET_W-1:0]    active_q;
	logic                invalid_q;
	logic                hit_s1;
	logic                out_valid_q;
	op_t                 op_q;
	logic [SYMBOL_W-1:0] sym_q;
	logic [SET_W-1:0]    acc_q;
	logic [RESULT_W-1:0] out_data_q;

	logic [SCNT_W:0]   eff_states;
	logic [SCNT_W:0]   eff_symbols;
	logic [SET_W-1:0]  live;
	logic              sym_ok;
	logic              load_ok;
	logic [AW-1:0]     load_addr;
	logic [AW-1:0]     scan_addr;
	logic [SET_W-1:0]  union_set;
	logic [SET_W-1:0]  next_set;
	logic [SET_W-1:0]  begin_set;
	logic              accepted;
	status_t           status;
	logic              accept;
	logic              out_load;

	// effective counts, clamped to 1..MAX
	always_comb begin
		if (cfg.state_count == '0) begin
			eff_states = (SCNT_W+1)'(1);
		end else if ({1'b0, cfg.state_count} > (SCNT_W+1)'(MAX_STATES)) begin
			eff_states = (SCNT_W+1)'(MAX_STATES);
		end else begin
			eff_states = {1'b0, cfg.state_count};
		end
		if (cfg.symbol_count == '0) begin
			eff_symbols = (SCNT_W+1)'(1);
		end else if ((SCNT_W+1)'(cfg.symbol_count) > (SCNT_W+1)'(MAX_SYMBOLS)) begin
			eff_symbols = (SCNT_W+1)'(MAX_SYMBOLS);
		end else begin
			eff_symbols = (SCNT_W+1)'(cfg.symbol_count);
		end
		for (int i = 0; i < SET_W; i++) begin
			live[i] = (SCNT_W+1)'(i) < eff_states;
		end
	end

	assign accept    = in_valid && in_ready;
	assign sym_ok    = (SCNT_W+1)'(in_symbol) < eff_symbols;
	assign load_ok   = ((SCNT_W+1)'(in_state) < (SCNT_W+1)'(MAX_STATES)) &&
		((SCNT_W+1)'(in_symbol) < (SCNT_W+1)'(MAX_SYMBOLS));
	assign load_addr = AW'(in_state) * AW'(MAX_SYMBOLS) + AW'(in_symbol);
	assign scan_addr = AW'(cnt_q) * AW'(MAX_SYMBOLS) + AW'(sym_q);
	assign begin_set = (SET_W'(1) << cfg.start_state) & live;

	// last row arrives in the drain cycle
	assign union_set = (acc_q | (hit_s1 ? mem_rdata : '0)) & live;
	assign next_set  = cfg.dfa_mode ? (union_set & (~union_set + SET_W'(1))) : union_set;

	assign accepted = (op_q == OP_END) && !invalid_q &&
		(|(active_q & cfg.accepting_mask & live));

	always_comb begin
		if (op_q == OP_LOAD) begin
			status = STS_OK;
		end else if (invalid_q) begin
			status = STS_INVALID;
		end else if (active_q == '0) begin
			status = STS_DEAD;
		end else begin
			status = STS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == AW'(DEPTH-1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_LOAD) begin
						mem_we    = load_ok;
						mem_waddr = load_addr;
						mem_wdata = in_targets;
						state_d   = ST_FINISH;
					end else if (in_op == OP_SYMBOL && sym_ok) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				mem_re    = 1'b1;
				mem_raddr = scan_addr;
				if (cnt_q == SW'(MAX_STATES-1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			active_q    <= '0;
			invalid_q   <= 1'b0;
			hit_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			hit_s1 <= (state_q == ST_SCAN) && active_q[STATE_W'(cnt_q)];
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + SW'(1);
			end
			if (accept) begin
				cnt_q <= '0;
				if (in_op == OP_BEGIN) begin
					active_q  <= begin_set;
					invalid_q <= 1'b0;
				end else if (in_op == OP_SYMBOL && !sym_ok) begin
					invalid_q <= 1'b1;
				end
			end
			if (state_q == ST_DRAIN) begin
				active_q <= next_set;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_op;
			sym_q <= in_symbol;
			acc_q <= '0;
		end else if (hit_s1) begin
			acc_q <= acc_q | mem_rdata;
		end
		if (out_load) begin
			out_data_q <= {status, accepted, active_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### design/finite_automaton_stepper_top.sv
// Top level of the finite automaton stepper: ports, configuration registers, table and sequencer.
// Flow: a load, begin or end word (or an out-of-alphabet symbol) goes from idle straight to the
//   finish state; a valid symbol word first scans one table row per state, then drains.
// The result register loads in the finish state once it is free, and m_tvalid rises with it.
// One word at a time: the next word is taken only after the finish state returns to idle.
// Reset: arst_n clears control state, then a clearing pass writes zeros to all
//   MAX_STATES * MAX_SYMBOLS table rows (1024 at the defaults) before s_tready rises.
module finite_automaton_stepper_top import fas_pkg::*; #(
	parameter int unsigned MAX_STATES  = FAS_MAX_STATES,
	parameter int unsigned MAX_SYMBOLS = FAS_MAX_SYMBOLS
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes, no read-back
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // [5:0] state_index, [9:6] symbol_index, [73:10] target_set
	input  logic [1:0]  s_tuser,   // [1:0] op
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [63:0] active_set, [64] accepted, [66:65] status
);

	localparam int unsigned DEPTH = MAX_STATES * MAX_SYMBOLS;
	localparam int unsigned AW    = $clog2(DEPTH);

	cfg_t cfg_q;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [SET_W-1:0]    mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic [SET_W-1:0]    mem_rdata;
	logic [RESULT_W-1:0] result;

	// Configuration registers. Writes must only land while the block is idle; the
	// block does not enforce this itself, and the sequencer reads them directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dfa_mode       <= DFA_MODE_RST;
			cfg_q.state_count    <= STATE_COUNT_RST;
			cfg_q.symbol_count   <= SYMBOL_COUNT_RST;
			cfg_q.start_state    <= START_STATE_RST;
			cfg_q.accepting_mask <= ACCEPTING_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DFA_MODE:       cfg_q.dfa_mode       <= cfg_data[0];
				CFG_STATE_COUNT:    cfg_q.state_count    <= cfg_data[SCNT_W-1:0];
				CFG_SYMBOL_COUNT:   cfg_q.symbol_count   <= cfg_data[YCNT_W-1:0];
				CFG_START_STATE:    cfg_q.start_state    <= cfg_data[STATE_W-1:0];
				CFG_ACCEPTING_MASK: cfg_q.accepting_mask <= cfg_data;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// Table memory: written by loads and the clearing pass, read one row per
	// cycle while a symbol is scanned.
	fas_table #(
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer with the active set, invalid flag and the result register. The
	// result register lets the next word in while the last result waits.
	fas_core #(
		.MAX_STATES  (MAX_STATES),
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (op_t'(s_tuser)),
		.in_state   (s_tdata[5:0]),
		.in_symbol  (s_tdata[9:6]),
		.in_targets (s_tdata[73:10]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (result),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	// pad the result to whole bytes
	assign m_tdata = {5'b0, result};

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for finite_automaton_stepper_top: queued stimulus, in-line predictor.
module tb_top;
	import fas_pkg::*;

	// one input word, split into its fields
	typedef struct {
		op_t                 op;
		logic [STATE_W-1:0]  state_index;
		logic [SYMBOL_W-1:0] symbol_index;
		logic [SET_W-1:0]    target_set;
	} fa_word_t;

	// one result word as the predictor sees it
	typedef struct {
		logic [SET_W-1:0] active_set;
		logic             accepted;
		status_t          status;
	} verdict_t;

	localparam int unsigned RANDOM_WORDS = 1950;
	localparam int unsigned IDLE_PCT     = 34;
	localparam int unsigned MAX_REPORTS  = 10;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata   = '0;   // [5:0] state_index, [9:6] symbol_index, [73:10] target_set
	logic [1:0]  s_tuser   = '0;   // [1:0] op
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [71:0] m_tdata;          // [63:0] active_set, [64] accepted, [66:65] status

	// stimulus waiting for the driver, and verdicts waiting for the monitor
	fa_word_t    pending_words[$];
	verdict_t    due_verdicts[$];
	fa_word_t    cur_word;
	verdict_t    want;
	int unsigned queued_words   = 0;
	int unsigned accepted_words = 0;
	int unsigned mismatches     = 0;
	logic        calm;

	// predictor's private copy of the table, the run state and the registers
	logic [SET_W-1:0]    trans_rows [FAS_MAX_STATES * FAS_MAX_SYMBOLS];
	logic [SET_W-1:0]    run_set;
	logic                bad_symbol;
	logic                cfg_dfa;
	logic [SCNT_W-1:0]   cfg_states;
	logic [YCNT_W-1:0]   cfg_symbols;
	logic [STATE_W-1:0]  cfg_start;
	logic [SET_W-1:0]    cfg_accept;

	always #5 clk = ~clk;

	finite_automaton_stepper_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// a window of words in which neither side idles
	assign calm = (accepted_words >= 900) && (accepted_words < 1250);

	// effective counts: zero acts as one, oversize clamps to the table size
	function automatic int unsigned clamp_count(int unsigned n, int unsigned top);
		if (n < 1) return 1;
		if (n > top) return top;
		return n;
	endfunction

	// steps the automaton by one word and returns the result it must produce
	function automatic verdict_t advance_automaton(fa_word_t w);
		verdict_t    v;
		logic [63:0] live;
		logic [63:0] next;
		int unsigned ns;
		int unsigned ny;
		ns = clamp_count(32'(cfg_states), FAS_MAX_STATES);
		ny = clamp_count(32'(cfg_symbols), FAS_MAX_SYMBOLS);
		live = (ns >= 64) ? '1 : ((64'd1 << ns) - 64'd1);
		v.accepted = 1'b0;
		case (w.op)
			OP_LOAD: begin
				trans_rows[{w.state_index, w.symbol_index}] = w.target_set;
			end
			OP_BEGIN: begin
				run_set = (64'd1 << cfg_start) & live;
				bad_symbol = 1'b0;
			end
			OP_SYMBOL: begin
				if (w.symbol_index >= ny) begin
					// out of the alphabet: flag the string, keep the set
					bad_symbol = 1'b1;
				end else begin
					next = '0;
					for (int s = 0; s < FAS_MAX_STATES; s++)
						if (run_set[s])
							next |= trans_rows[{s[STATE_W-1:0], w.symbol_index}];
					next &= live;
					// deterministic mode keeps only the lowest target
					if (cfg_dfa)
						next &= (~next + 64'd1);
					run_set = next;
				end
			end
			default: begin
				v.accepted = !bad_symbol && ((run_set & cfg_accept & live) != '0);
			end
		endcase
		v.active_set = run_set;
		if (w.op == OP_LOAD)
			v.status = STS_OK;
		else if (bad_symbol)
			v.status = STS_INVALID;
		else if (run_set == '0)
			v.status = STS_DEAD;
		else
			v.status = STS_OK;
		return v;
	endfunction

	function automatic void push_word(op_t op, int unsigned st,
			int unsigned sym, logic [SET_W-1:0] tgt);
		fa_word_t w;
		w.op = op;
		w.state_index = STATE_W'(st);
		w.symbol_index = SYMBOL_W'(sym);
		w.target_set = tgt;
		pending_words.push_back(w);
		queued_words++;
	endfunction

	// a few target bits among the states in use, now and then something wilder
	function automatic logic [63:0] rand_set(int unsigned n);
		logic [63:0] s;
		s = '0;
		case ($urandom_range(7))
			0: s = {$urandom, $urandom};
			1: s = '0;
			default: repeat ($urandom_range(1, 3)) s[$urandom_range(n - 1)] = 1'b1;
		endcase
		return s;
	endfunction

	task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
	endtask

	// writes all five registers back to back; only called with the block idle
	task automatic apply_config(input logic dfa, input logic [SCNT_W-1:0] nstates,
			input logic [YCNT_W-1:0] nsyms, input logic [STATE_W-1:0] start,
			input logic [SET_W-1:0] accept);
		write_reg(CFG_DFA_MODE, 64'(dfa));
		write_reg(CFG_STATE_COUNT, 64'(nstates));
		write_reg(CFG_SYMBOL_COUNT, 64'(nsyms));
		write_reg(CFG_START_STATE, 64'(start));
		write_reg(CFG_ACCEPTING_MASK, accept);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_dfa     = dfa;
		cfg_states  = nstates;
		cfg_symbols = nsyms;
		cfg_start   = start;
		cfg_accept  = accept;
		// queue pushes land away from the driver's edge
		@(negedge clk);
	endtask

	// everything sent, everything answered, then a short settle
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_words.size() != 0 || s_tvalid || due_verdicts.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// driver: predicts on acceptance, then offers the next word or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				due_verdicts.push_back(advance_automaton(cur_word));
				accepted_words <= accepted_words + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					cur_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {6'b0, cur_word.target_set, cur_word.symbol_index,
						cur_word.state_index};
					s_tuser  <= cur_word.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result word against the oldest verdict, stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result word %h", m_tdata);
				end else begin
					want = due_verdicts.pop_front();
					if (m_tdata[63:0] !== want.active_set || m_tdata[64] !== want.accepted ||
							m_tdata[66:65] !== want.status) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: active %h/%h accepted %0b/%0b status %0d/%0d",
								want.active_set, m_tdata[63:0], want.accepted, m_tdata[64],
								want.status, m_tdata[66:65]);
					end
				end
			end
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		int unsigned         dfa;
		int unsigned         nstates;
		int unsigned         nsyms;
		int unsigned         start;
		logic [SET_W-1:0]    accept;
		int unsigned         ns;
		int unsigned         ny;
		int unsigned         phase_end;
		int unsigned         pick;
		int unsigned         goal;

		foreach (trans_rows[i])
			trans_rows[i] = '0;
		run_set     = '0;
		bad_symbol  = 1'b0;
		cfg_dfa     = DFA_MODE_RST;
		cfg_states  = STATE_COUNT_RST;
		cfg_symbols = SYMBOL_COUNT_RST;
		cfg_start   = START_STATE_RST;
		cfg_accept  = ACCEPTING_MASK_RST;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// table clearing pass runs first; ready rises once it is done
		do @(negedge clk);
		while (s_tready !== 1'b1);

		// directed: no begin yet, full and single-bit rows, acceptance, repeat end, dead set
		apply_config(1'b0, 7'd64, 5'd16, 6'd0, '1);
		push_word(OP_SYMBOL, 0, 0, '0);
		push_word(OP_END, 0, 0, '0);
		push_word(OP_LOAD, 0, 0, '1);
		push_word(OP_LOAD, 63, 15, 64'h8000_0000_0000_0000);
		push_word(OP_LOAD, 63, 0, 64'h1);
		push_word(OP_BEGIN, 0, 0, '0);
		push_word(OP_SYMBOL, 0, 0, '0);
		push_word(OP_SYMBOL, 0, 15, '0);
		push_word(OP_END, 0, 0, '0);
		push_word(OP_END, 0, 0, '0);
		push_word(OP_SYMBOL, 0, 3, '0);
		push_word(OP_SYMBOL, 0, 0, '0);
		push_word(OP_END, 0, 0, '0);
		wait_drained();

		// directed: deterministic mode, small alphabet, invalid symbol sticks until begin
		apply_config(1'b1, 7'd64, 5'd4, 6'd63, 64'h1);
		push_word(OP_BEGIN, 0, 0, '0);
		push_word(OP_SYMBOL, 0, 0, '0);
		push_word(OP_SYMBOL, 0, 0, '0);
		push_word(OP_SYMBOL, 0, 5, '0);
		push_word(OP_SYMBOL, 0, 0, '0);
		push_word(OP_END, 0, 0, '0);
		push_word(OP_BEGIN, 0, 0, '0);
		wait_drained();

		// directed: zero counts act as one, start state outside the states in use
		apply_config(1'b0, 7'd0, 5'd0, 6'd5, '1);
		push_word(OP_BEGIN, 0, 0, '0);
		push_word(OP_LOAD, 1, 1, 64'h2);
		wait_drained();

		// directed: oversize counts clamp to the table size
		apply_config(1'b0, 7'd127, 5'd31, 6'd0, '0);
		push_word(OP_BEGIN, 0, 0, '0);
		push_word(OP_SYMBOL, 0, 15, '0);
		push_word(OP_END, 0, 0, '0);
		wait_drained();

		// random phases: new settings, a fresh batch of table rows, then strings
		goal = queued_words + RANDOM_WORDS;
		while (queued_words < goal) begin
			dfa = $urandom_range(1);
			case ($urandom_range(9))
				0, 1, 2, 3: nstates = $urandom_range(1, 8);
				4, 5:       nstates = $urandom_range(9, 63);
				6:          nstates = 64;
				7:          nstates = 0;
				8:          nstates = $urandom_range(65, 127);
				default:    nstates = $urandom_range(127);
			endcase
			case ($urandom_range(9))
				0, 1, 2, 3: nsyms = $urandom_range(1, 4);
				4, 5:       nsyms = $urandom_range(5, 15);
				6:          nsyms = 16;
				7:          nsyms = 0;
				8:          nsyms = $urandom_range(17, 31);
				default:    nsyms = $urandom_range(31);
			endcase
			ns = clamp_count(nstates, FAS_MAX_STATES);
			ny = clamp_count(nsyms, FAS_MAX_SYMBOLS);
			start = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(ns - 1);
			case ($urandom_range(7))
				0:       accept = '0;
				1:       accept = '1;
				2:       accept = {$urandom, $urandom};
				default: accept = rand_set(ns);
			endcase
			apply_config(1'(dfa), SCNT_W'(nstates), YCNT_W'(nsyms), STATE_W'(start), accept);

			// rows for the states and symbols in use, a few anywhere in the table
			repeat ($urandom_range(8, 40)) begin
				if ($urandom_range(9) == 0)
					push_word(OP_LOAD, $urandom_range(63), $urandom_range(15), {$urandom, $urandom});
				else
					push_word(OP_LOAD, $urandom_range(ns - 1), $urandom_range(ny - 1), rand_set(ns));
			end

			phase_end = queued_words + $urandom_range(100, 160);
			while (queued_words < phase_end) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					// well-formed string, mostly in-alphabet symbols
					push_word(OP_BEGIN, $urandom_range(63), $urandom_range(15), {$urandom, $urandom});
					repeat ($urandom_range(0, 12))
						push_word(OP_SYMBOL, $urandom_range(63),
							($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(ny - 1),
							{$urandom, $urandom});
					push_word(OP_END, $urandom_range(63), $urandom_range(15), {$urandom, $urandom});
				end else if (pick < 92) begin
					// noise: any op with any fields, breaks strings apart
					push_word(op_t'($urandom_range(3)), $urandom_range(63), $urandom_range(15),
						{$urandom, $urandom});
				end else begin
					// table update in the middle of a run
					push_word(OP_LOAD, $urandom_range(ns - 1), $urandom_range(ny - 1), rand_set(ns));
				end
			end
			wait_drained();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && due_verdicts.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
